@@ rtl/assert_macros.svh @@
// Assertion macros shared by the timer table RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge while reset is released.
`define DETT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("timer table assertion failed");

// Checked on every rising edge, reset included.
`define DETT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("timer table assertion failed");

`else

`define DETT_ASSERT(lbl, clk, rst_n, prop)
`define DETT_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/dett_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer table package
// Types, sizes and command and status codes of the delayed-event timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package dett_pkg;

    localparam int SLOTS           = 32;
    localparam int PRIORITY_LEVELS = 8;
    localparam int MAX_DISPATCH    = 32;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int DONE_W = $clog2(MAX_DISPATCH + 1);

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_UPDATE = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_TICK   = 3'd4;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_PARAM = 2'd1;
    localparam logic [1:0] STS_NO_SLOT   = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    localparam logic KIND_STATUS   = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  priority_req;
        logic [31:0] event_code;
        logic [31:0] delay;
        logic [31:0] current_time;
        logic [15:0] callback_id;
    } t_in_req;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [7:0]  dispatch_priority;
        logic [31:0] dispatch_event;
        logic [15:0] dispatch_callback;
        logic        cancel_ready;
        logic [5:0]  active_count;
        logic        last;
    } t_out_rsp;

    typedef struct packed {
        logic        valid;
        logic [7:0]  prio;
        logic [31:0] event_code;
        logic [15:0] callback;
        logic [31:0] deadline;
    } t_slot;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_ring_ctl;

    function automatic logic [5:0] sat_count(input logic [CNT_W-1:0] c);
        if (32'(c) > 32'd63) begin
            return 6'd63;
        end
        return 6'(c);
    endfunction

endpackage

`default_nettype wire

@@ rtl/dett_cell.sv @@
// ----------------------------------------------------------------------------
// Timer table cell
// Holds one timer slot and passes it to its neighbor whenever the ring shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module dett_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dett_pkg::t_ring_ctl i_ctl,
    input  wire dett_pkg::t_slot    i_slot,
    output dett_pkg::t_slot         o_slot
);
    import dett_pkg::*;

    logic        r_valid;
    logic [7:0]  r_prio;
    logic [31:0] r_event;
    logic [15:0] r_callback;
    logic [31:0] r_deadline;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_prio     <= i_slot.prio;
            r_event    <= i_slot.event_code;
            r_callback <= i_slot.callback;
            r_deadline <= i_slot.deadline;
        end
    end

    assign o_slot = '{valid: r_valid, prio: r_prio, event_code: r_event,
                      callback: r_callback, deadline: r_deadline};

endmodule

`default_nettype wire

@@ rtl/dett_ctrl.sv @@
// ----------------------------------------------------------------------------
// Timer table sequencer
// Decodes requests, walks the slot ring one cell per cycle unless a tick stalls, and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dett_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_req_valid,
    output logic                     o_req_ready,
    input  wire dett_pkg::t_in_req   i_req,
    output logic                     o_rsp_valid,
    input  wire logic                i_rsp_ready,
    output dett_pkg::t_out_rsp       o_rsp,
    input  wire dett_pkg::t_slot     i_head,
    output dett_pkg::t_slot          o_tail,
    output dett_pkg::t_ring_ctl      o_ctl
);
    import dett_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_IMM  = 2'd2;
    localparam logic [1:0] ST_STAT = 2'd3;

    logic [1:0]       r_state,     n_state;
    t_in_req          r_req,       n_req;
    logic [31:0]      r_new_dl,    n_new_dl;
    logic [IDX_W-1:0] r_idx,       n_idx;
    logic             r_found,     n_found;
    logic [DONE_W-1:0] r_done,     n_done;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [1:0]       r_status,    n_status;
    logic             r_cancel,    n_cancel;
    logic             r_out_valid, n_out_valid;
    t_out_rsp         r_out,       n_out;

    logic out_free;
    logic key_ok;
    logic hit;
    logic take;
    logic expire;

    assign out_free = !r_out_valid || i_rsp_ready;
    assign key_ok   = (i_req.event_code != 32'd0) &&
                      (32'(i_req.priority_req) < PRIORITY_LEVELS);
    assign hit      = i_head.valid && (i_head.prio == r_req.priority_req) &&
                      (i_head.event_code == r_req.event_code);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_new_dl    = r_new_dl;
        n_idx       = r_idx;
        n_found     = r_found;
        n_done      = r_done;
        n_count     = r_count;
        n_status    = r_status;
        n_cancel    = r_cancel;
        n_out_valid = r_out_valid && !i_rsp_ready;
        n_out       = r_out;
        o_tail      = i_head;
        o_ctl       = '{shift: 1'b0, clear: 1'b0};
        take        = 1'b0;
        expire      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_req    = i_req;
                    n_new_dl = i_req.current_time + i_req.delay;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_done   = '0;
                    n_cancel = 1'b0;
                    n_status = STS_OK;
                    case (i_req.command)
                        CMD_ADD: begin
                            if (!key_ok || i_req.callback_id == 16'd0) begin
                                n_status = STS_BAD_PARAM;
                                n_state  = ST_STAT;
                            end else if (i_req.delay == 32'd0) begin
                                n_state = ST_IMM;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        CMD_UPDATE, CMD_REMOVE: begin
                            if (!key_ok) begin
                                n_status = STS_BAD_PARAM;
                                n_state  = ST_STAT;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        CMD_CLEAR: begin
                            o_ctl.clear = 1'b1;
                            n_count     = '0;
                            n_state     = ST_STAT;
                        end
                        CMD_TICK: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_status = STS_BAD_PARAM;
                            n_state  = ST_STAT;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                o_ctl.shift = 1'b1;
                case (r_req.command)
                    CMD_ADD: begin
                        if (!r_found && !i_head.valid) begin
                            take    = 1'b1;
                            o_tail  = '{valid: 1'b1, prio: r_req.priority_req,
                                        event_code: r_req.event_code,
                                        callback: r_req.callback_id,
                                        deadline: r_new_dl};
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    CMD_UPDATE: begin
                        if (!r_found && hit) begin
                            take            = 1'b1;
                            o_tail.deadline = r_new_dl;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!r_found && hit) begin
                            take         = 1'b1;
                            o_tail.valid = 1'b0;
                            n_count      = r_count - CNT_W'(1);
                        end
                    end
                    default: begin
                        // Tick: expired slots leave through the output register.
                        expire = i_head.valid &&
                                 (r_req.current_time >= i_head.deadline) &&
                                 (32'(r_done) < MAX_DISPATCH);
                        if (expire) begin
                            if (out_free) begin
                                o_tail.valid = 1'b0;
                                n_count      = r_count - CNT_W'(1);
                                n_done       = r_done + DONE_W'(1);
                                n_out_valid  = 1'b1;
                                n_out = '{kind: KIND_DISPATCH, status: STS_OK,
                                          dispatch_priority: i_head.prio,
                                          dispatch_event: i_head.event_code,
                                          dispatch_callback: i_head.callback,
                                          cancel_ready: 1'b0,
                                          active_count: sat_count(n_count),
                                          last: 1'b0};
                            end else begin
                                o_ctl.shift = 1'b0;
                            end
                        end
                    end
                endcase

                if (take) begin
                    n_found = 1'b1;
                end

                if (o_ctl.shift) begin
                    n_idx = r_idx + IDX_W'(1);
                    if (r_idx == IDX_W'(SLOTS - 1)) begin
                        n_idx   = '0;
                        n_state = ST_STAT;
                        case (r_req.command)
                            CMD_ADD: begin
                                n_status = n_found ? STS_OK : STS_NO_SLOT;
                                n_cancel = 1'b1;
                            end
                            CMD_UPDATE, CMD_REMOVE: begin
                                n_status = n_found ? STS_OK : STS_NOT_FOUND;
                            end
                            default: begin
                                n_status = STS_OK;
                            end
                        endcase
                    end
                end
            end

            ST_IMM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{kind: KIND_DISPATCH, status: STS_OK,
                              dispatch_priority: r_req.priority_req,
                              dispatch_event: r_req.event_code,
                              dispatch_callback: r_req.callback_id,
                              cancel_ready: 1'b1,
                              active_count: sat_count(r_count),
                              last: 1'b0};
                    n_status = STS_OK;
                    n_cancel = 1'b0;
                    n_state  = ST_STAT;
                end
            end

            default: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{kind: KIND_STATUS, status: r_status,
                              dispatch_priority: 8'd0, dispatch_event: 32'd0,
                              dispatch_callback: 16'd0, cancel_ready: r_cancel,
                              active_count: sat_count(r_count), last: 1'b1};
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_done      <= '0;
            r_count     <= '0;
            r_status    <= STS_OK;
            r_cancel    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_done      <= n_done;
            r_count     <= n_count;
            r_status    <= n_status;
            r_cancel    <= n_cancel;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_new_dl <= n_new_dl;
        r_out    <= n_out;
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    `DETT_ASSERT(a_count_bound, i_clk, i_rst_n, 32'(r_count) <= SLOTS)
    `DETT_ASSERT(a_one_request, i_clk, i_rst_n,
        (i_req_valid && o_req_ready) |=> !o_req_ready)
    `DETT_ASSERT(a_idx_home, i_clk, i_rst_n, (r_state != ST_SCAN) |-> (r_idx == '0))

endmodule

`default_nettype wire

@@ rtl/delayed_event_timer_table_core.sv @@
// ----------------------------------------------------------------------------
// Delayed-event timer table
// Timer slots kept in a ring of cells, scanned by a single sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_req_valid / o_req_ready, one command per request.
//   Results leave on o_rsp_valid / i_rsp_ready; every request ends with one
//   status result marked by last, and add with zero delay or tick may send
//   dispatch results before it, in slot order.
//   Add with a nonzero delay, update, remove and tick rotate the slot ring
//   once, one cell per cycle unless a tick holds the rotation. Clear, bad
//   parameters and zero-delay add do not rotate the ring.
//   One request is worked on at a time; the next request is accepted as soon
//   as the status result sits in the output register.
//   When the receiver stalls, a tick that has an expired slot at the ring head
//   holds the rotation until the output register frees up.
//   Reset clears every slot valid bit and the armed count.
// ----------------------------------------------------------------------------
`default_nettype none

module delayed_event_timer_table_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire dett_pkg::t_in_req i_req,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_ready,
    output dett_pkg::t_out_rsp     o_rsp
);
    import dett_pkg::*;

    t_slot     w_slot [SLOTS];
    t_slot     w_tail;
    t_ring_ctl w_ctl;

    dett_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_head      (w_slot[0]),
        .o_tail      (w_tail),
        .o_ctl       (w_ctl)
    );

    // The head cell is examined each cycle; its updated copy enters at the tail.
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        if (g == SLOTS - 1) begin : g_tail
            dett_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_slot  (w_tail),
                .o_slot  (w_slot[g])
            );
        end else begin : g_mid
            dett_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_slot  (w_slot[g + 1]),
                .o_slot  (w_slot[g])
            );
        end
    end

endmodule

`default_nettype wire
